@@ hdl/ldw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldw_pkg - shared types and constants of the LCD decimal digit writer
// Field widths, the segment table and the control/status bundles.
// ----------------------------------------------------------------------------
package ldw_pkg;

    localparam int OPCODE_W    = 1;
    localparam int NUMBER_W    = 32;
    localparam int DIGIT_W     = 8;
    localparam int POSITION_W  = 8;
    localparam int REG_INDEX_W = 5;
    localparam int REG_VALUE_W = 8;

    localparam int IMAGE_DEPTH = 12;
    localparam int SLOT_W      = 4;
    localparam int NIBBLES     = 4;
    localparam int NIB_W       = 2;
    localparam int REG_STRIDE  = 5;
    localparam int POS_W       = 3;
    localparam int BCD_W       = 4;
    localparam int MAX_REG     = 17;

    localparam logic [OPCODE_W-1:0] OP_NUMBER = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_DIGIT  = 1'b1;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = 8'd9;

    // divide by ten: quotient = (v * DIV10_RECIP) >> DIV10_SHIFT, exact for
    // every 32-bit unsigned v
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;
    localparam int          DIV_CYCLES  = 2;

    // segment codes, nibble 0 in the low bits
    localparam logic [15:0] SEG_TABLE [10] = '{
        16'h1551, 16'h0110, 16'h1E11, 16'h1B11, 16'h0B50,
        16'h1B41, 16'h1F41, 16'h0111, 16'h1F51, 16'h0B51
    };

    localparam logic [7:0] HIGH_NIB_MASK = 8'hF0;
    localparam logic [7:0] LOW_NIB_MASK  = 8'h0F;

    typedef struct packed {
        logic accept_en;
        logic load_num;
        logic load_digit;
        logic div_step;
        logic write_nib;
        logic next_digit;
    } ldw_cmd_t;

    typedef struct packed {
        logic num_go;
        logic dig_go;
        logic div_last;
        logic last_nib;
        logic more;
        logic out_free;
    } ldw_status_t;

endpackage
`default_nettype wire

@@ hdl/ldw_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldw_in_if - request channel
// Valid/ready channel carrying one number or one positioned digit.
// ----------------------------------------------------------------------------
interface ldw_in_if;
    import ldw_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [OPCODE_W-1:0]          opcode;
    logic signed [NUMBER_W-1:0]   number;
    logic signed [DIGIT_W-1:0]    digit_value;
    logic signed [POSITION_W-1:0] position;

    modport source (output valid, opcode, number, digit_value, position, input ready);
    modport sink   (input valid, opcode, number, digit_value, position, output ready);
endinterface
`default_nettype wire

@@ hdl/ldw_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldw_out_if - register write channel
// Valid/ready channel carrying one LCD data register write.
// ----------------------------------------------------------------------------
interface ldw_out_if;
    import ldw_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [REG_INDEX_W-1:0] reg_index;
    logic [REG_VALUE_W-1:0] reg_value;
    logic                   last_write;

    modport source (output valid, reg_index, reg_value, last_write, input ready);
    modport sink   (input valid, reg_index, reg_value, last_write, output ready);
endinterface
`default_nettype wire

@@ hdl/lcd_decimal_digit_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_decimal_digit_writer - decimal digits to segment LCD register writes
// Keeps a twelve-byte display image and emits each byte it updates.
// ----------------------------------------------------------------------------
// Usage:
//   req carries an item: opcode 0 shows a whole number, opcode 1 shows one
//   digit at one position. A transfer happens when valid and ready are high.
//   rsp carries one LCD data register write per transfer (index and new byte);
//   last_write marks the final write caused by an item.
//   A number is split into decimal digits from the right. Each digit goes
//   through a divide by ten (reciprocal multiply, then remainder) and then
//   four nibble writes; a single digit goes straight to its nibble writes,
//   and an item that writes nothing leaves the block idle. One item is
//   worked at a time; req.ready is high only between items.
//   Reset clears the display image and drops any pending write.
//   When the receiver stalls, the write register holds its transfer and the
//   sequencer waits before its next write; the last write of an item may
//   still wait while the next item is taken.
// ----------------------------------------------------------------------------
module lcd_decimal_digit_writer #(
    parameter int DIGIT_COUNT  = 6,
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ldw_in_if.sink    req,
    ldw_out_if.source rsp
);
    import ldw_pkg::*;

    ldw_cmd_t    cmd;
    ldw_status_t status;

    // sequencer: decides when to load, divide, write and move on
    ldw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // datapath: divider, display image and write register
    ldw_datapath #(
        .DIGIT_COUNT  (DIGIT_COUNT),
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .rsp    (rsp),
        .cmd    (cmd),
        .status (status)
    );

`ifndef ASSERT_OFF
    // a write that is not the last of its item means the block is still busy
    a_busy_mid_item : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.last_write |-> !req.ready)
        else $error("intermediate write pending while block takes items");

    // a non-positive number is dropped at once
    a_drop_nonpositive : assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && (req.opcode == OP_NUMBER) &&
        (req.number[NUMBER_WIDTH-1] || (req.number[NUMBER_WIDTH-1:0] == '0))
        |=> req.ready)
        else $error("non-positive number did not leave the block idle");

    // written register numbers stay inside the LCD data range
    a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.reg_index <= REG_INDEX_W'(MAX_REG)))
        else $error("register index out of range");
`endif

endmodule
`default_nettype wire

@@ hdl/ldw_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldw_datapath - divider, display image and output register
// Divide by ten, segment merge into the image, write register.
// ----------------------------------------------------------------------------
module ldw_datapath #(
    parameter int DIGIT_COUNT  = 6,
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ldw_in_if.sink                req,
    ldw_out_if.source             rsp,
    input  wire ldw_pkg::ldw_cmd_t    cmd,
    output ldw_pkg::ldw_status_t      status
);
    import ldw_pkg::*;

    localparam int CNT_W = $clog2(DIV_CYCLES);

    logic [NUMBER_WIDTH-1:0] val_reg, val_next;
    logic [NUMBER_WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [BCD_W-1:0]        digit_reg, digit_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [NIB_W-1:0]        nib_reg, nib_next;
    logic [7:0]              image_reg [IMAGE_DEPTH];

    logic                    out_valid_reg, out_valid_next;
    logic [REG_INDEX_W-1:0]  out_index_reg;
    logic [REG_VALUE_W-1:0]  out_value_reg;
    logic                    out_last_reg;

    logic [NUMBER_WIDTH-1:0] num_slice;
    logic                    num_ok, dig_ok;
    logic [DIGIT_W-1:0]      dv_u;
    logic [POSITION_W-1:0]   ps_u;
    logic [31:0]             val_wide;
    logic [63:0]             product;
    logic [NUMBER_WIDTH-1:0] quotient;
    logic [BCD_W-1:0]        ten_q_low;
    logic [BCD_W-1:0]        rem_digit;
    logic [1:0]              col;
    logic                    odd;
    logic [SLOT_W-1:0]       slot;
    logic [15:0]             seg_code;
    logic [3:0]              nib_val;
    logic [7:0]              cur_byte, new_byte;
    logic [REG_INDEX_W-1:0]  reg_idx;
    logic                    more;

    // input qualification
    assign num_slice = req.number[NUMBER_WIDTH-1:0];
    assign num_ok    = !num_slice[NUMBER_WIDTH-1] && (num_slice != '0);
    assign dv_u      = req.digit_value;
    assign ps_u      = req.position;
    assign dig_ok    = (dv_u <= DIGIT_MAX) && (ps_u < POSITION_W'(DIGIT_COUNT));

    // divide by ten: reciprocal multiply into quo_reg, then take the
    // remainder from the low four bits of value and ten times quotient
    assign val_wide  = 32'(val_reg);
    assign product   = {32'h0, val_wide} * {32'h0, DIV10_RECIP};
    assign quotient  = NUMBER_WIDTH'(product[63:DIV10_SHIFT]);
    assign ten_q_low = {quo_reg[2:0], 1'b0} + {quo_reg[0], 3'b000};
    assign rem_digit = val_reg[BCD_W-1:0] - ten_q_low;

    // nibble merge
    assign col      = pos_reg[POS_W-1:1];
    assign odd      = pos_reg[0];
    assign slot     = {1'b0, nib_reg, 1'b0} + {2'b00, nib_reg} + {2'b00, col};
    assign seg_code = SEG_TABLE[digit_reg];
    assign nib_val  = seg_code[4*nib_reg +: 4];
    assign cur_byte = image_reg[slot];
    assign new_byte = odd ? ({nib_val, 4'h0} | (cur_byte & LOW_NIB_MASK))
                          : ((cur_byte & HIGH_NIB_MASK) | {4'h0, nib_val});
    assign reg_idx  = REG_INDEX_W'(col) + REG_INDEX_W'(nib_reg) * REG_INDEX_W'(REG_STRIDE);
    assign more     = (val_reg != '0) && (pos_reg != '0);

    assign status.num_go   = req.valid && (req.opcode == OP_NUMBER) && num_ok;
    assign status.dig_go   = req.valid && (req.opcode == OP_DIGIT) && dig_ok;
    assign status.div_last = (cnt_reg == '0);
    assign status.last_nib = (nib_reg == NIB_W'(NIBBLES - 1));
    assign status.more     = more;
    assign status.out_free = !out_valid_reg || rsp.ready;

    assign req.ready      = cmd.accept_en;
    assign rsp.valid      = out_valid_reg;
    assign rsp.reg_index  = out_index_reg;
    assign rsp.reg_value  = out_value_reg;
    assign rsp.last_write = out_last_reg;

    always_comb
    begin
        val_next   = val_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        digit_next = digit_reg;
        pos_next   = pos_reg;
        nib_next   = nib_reg;
        if (cmd.load_num)
        begin
            val_next = num_slice;
            cnt_next = CNT_W'(DIV_CYCLES - 1);
            pos_next = POS_W'(DIGIT_COUNT - 1);
        end
        if (cmd.load_digit)
        begin
            val_next   = '0;
            digit_next = dv_u[BCD_W-1:0];
            pos_next   = ps_u[POS_W-1:0];
            nib_next   = '0;
        end
        if (cmd.div_step)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                digit_next = rem_digit;
                val_next   = quo_reg;
                nib_next   = '0;
            end
            else
            begin
                quo_next = quotient;
            end
        end
        if (cmd.write_nib)
        begin
            nib_next = nib_reg + 1'b1;
        end
        if (cmd.next_digit)
        begin
            pos_next = pos_reg - 1'b1;
            cnt_next = CNT_W'(DIV_CYCLES - 1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write_nib)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg       <= '0;
            quo_reg       <= '0;
            cnt_reg       <= '0;
            digit_reg     <= '0;
            pos_reg       <= '0;
            nib_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < IMAGE_DEPTH; i++)
            begin
                image_reg[i] <= '0;
            end
        end
        else
        begin
            val_reg       <= val_next;
            quo_reg       <= quo_next;
            cnt_reg       <= cnt_next;
            digit_reg     <= digit_next;
            pos_reg       <= pos_next;
            nib_reg       <= nib_next;
            out_valid_reg <= out_valid_next;
            if (cmd.write_nib)
            begin
                image_reg[slot] <= new_byte;
            end
        end
    end

    // write payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.write_nib)
        begin
            out_index_reg <= reg_idx;
            out_value_reg <= new_byte;
            out_last_reg  <= status.last_nib && !more;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ldw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ldw_ctrl - sequencing state machine
// Steps a number through divide and write phases, a digit through writes.
// ----------------------------------------------------------------------------
module ldw_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ldw_pkg::ldw_status_t  status,
    output ldw_pkg::ldw_cmd_t          cmd
);
    import ldw_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIVIDE = 3'b010,
        S_WRITE  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.accept_en  = 1'b1;
                cmd.load_num   = status.num_go;
                cmd.load_digit = status.dig_go;
                if (status.num_go)
                begin
                    state_next = S_DIVIDE;
                end
                else if (status.dig_go)
                begin
                    state_next = S_WRITE;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                // hold while the output register is still occupied
                if (status.out_free)
                begin
                    cmd.write_nib = 1'b1;
                    if (status.last_nib)
                    begin
                        if (status.more)
                        begin
                            cmd.next_digit = 1'b1;
                            state_next     = S_DIVIDE;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ sim/lcd_decimal_digit_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_decimal_digit_writer_tb - self-checking bench of the LCD digit writer
// Offers numbers and positioned digits on the request channel and keeps its
// own copy of the twelve-byte display image. Every register write seen on
// the response channel is compared with the predicted write. Both sides
// idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module lcd_decimal_digit_writer_tb;
    import ldw_pkg::*;

    localparam int DIGITS       = 6;
    localparam int ITEM_COUNT   = 150;
    localparam int DRAIN_CYCLES = 250;   // room for any stray write to show up
    localparam int HOLD_START   = 300;
    localparam int HOLD_CYCLES  = 600;

    // one request as offered to the block
    typedef struct {
        logic [OPCODE_W-1:0]          opcode;
        logic signed [NUMBER_W-1:0]   number;
        logic signed [DIGIT_W-1:0]    digit_value;
        logic signed [POSITION_W-1:0] position;
    } lcd_request_t;

    // one LCD data register write
    typedef struct {
        logic [REG_INDEX_W-1:0] reg_index;
        logic [REG_VALUE_W-1:0] reg_value;
        logic                   last_write;
    } lcd_write_t;

    logic clk;
    logic rst_n;
    bit   stim_on;
    bit   hold_rsp;

    ldw_in_if  req_ch ();
    ldw_out_if rsp_ch ();

    lcd_decimal_digit_writer #(
        .DIGIT_COUNT  (DIGITS),
        .NUMBER_WIDTH (NUMBER_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    lcd_request_t pending_requests [$];
    lcd_write_t   expected_writes [$];
    logic [7:0]   shown_image [IMAGE_DEPTH];

    bit          req_taken;
    bit          rsp_taken;
    int unsigned req_gap;
    int unsigned req_quiet;
    int unsigned rsp_gap;
    int unsigned rsp_quiet;
    int unsigned mismatch_count;
    int unsigned requests_taken;
    int unsigned writes_checked;

    // ------------------------------------------------------------------------
    // Clock, 2 ns period
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give every block input a known value from time zero.
    initial
    begin
        req_ch.valid       = 1'b0;
        req_ch.opcode      = OP_NUMBER;
        req_ch.number      = '0;
        req_ch.digit_value = '0;
        req_ch.position    = '0;
        rsp_ch.ready       = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Segment code of a decimal digit, nibble 0 in the low bits
    // ------------------------------------------------------------------------
    function automatic logic [15:0] segment_code(input int unsigned d);
        case (d)
            0:       return 16'h1551;
            1:       return 16'h0110;
            2:       return 16'h1E11;
            3:       return 16'h1B11;
            4:       return 16'h0B50;
            5:       return 16'h1B41;
            6:       return 16'h1F41;
            7:       return 16'h0111;
            8:       return 16'h1F51;
            default: return 16'h0B51;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Idle length: mostly none or short, now and then long, and from time to
    // time a quiet stretch with no idling at all.
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap(inout int unsigned quiet_left);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_left > 0)
        begin
            quiet_left = quiet_left - 1;
            return 0;
        end
        if (r < 3)
        begin
            quiet_left = $urandom_range(20, 40);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Predictor: merge the nibbles of one digit into the image copy and queue
    // one write per byte touched, changed or not.
    // ------------------------------------------------------------------------
    task automatic show_digit(input int unsigned d, input int unsigned p, inout int n);
        logic [15:0] code;
        logic [3:0]  nib;
        logic [7:0]  cur;
        lcd_write_t  wr;
        int unsigned col;
        int unsigned slot;
        int          k;
        code = segment_code(d);
        col  = p / 2;
        for (k = 0; k < NIBBLES; k++)
        begin
            nib  = code[4*k +: 4];
            slot = 3 * k + col;
            cur  = shown_image[slot];
            // odd positions own the high nibble, even ones the low nibble
            if (p % 2 == 1)
                shown_image[slot] = {nib, cur[3:0]};
            else
                shown_image[slot] = (cur & HIGH_NIB_MASK) | {4'h0, nib};
            wr.reg_index  = REG_INDEX_W'(col + REG_STRIDE * k);
            wr.reg_value  = shown_image[slot];
            wr.last_write = 1'b0;
            expected_writes.push_back(wr);
            n = n + 1;
        end
    endtask

    task automatic predict_writes(input lcd_request_t rq);
        longint value;
        int     dv;
        int     ps;
        int     pos;
        int     n;
        n = 0;
        if (rq.opcode == OP_NUMBER)
        begin
            // zero and negative numbers show nothing; digits past the sixth
            // from the right are dropped
            value = longint'(rq.number);
            pos   = DIGITS - 1;
            while (value > 0 && pos >= 0)
            begin
                show_digit(int'(value % 10), pos, n);
                value = value / 10;
                pos   = pos - 1;
            end
        end
        else
        begin
            dv = int'(rq.digit_value);
            ps = int'(rq.position);
            if (dv >= 0 && dv <= 9 && ps >= 0 && ps < DIGITS)
                show_digit(dv, ps, n);
        end
        if (n > 0)
            expected_writes[expected_writes.size() - 1].last_write = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_request(input logic [OPCODE_W-1:0] op, input int num,
                                 input int dv, input int ps);
        lcd_request_t rq;
        rq.opcode      = op;
        rq.number      = num;
        rq.digit_value = dv[DIGIT_W-1:0];
        rq.position    = ps[POSITION_W-1:0];
        pending_requests.push_back(rq);
    endtask

    // A positive number of the given digit count.
    function automatic int number_of_digits(input int unsigned count);
        int unsigned lo;
        int unsigned i;
        lo = 1;
        for (i = 1; i < count; i++)
            lo = lo * 10;
        return int'($urandom_range(lo, lo * 10 - 1));
    endfunction

    // ------------------------------------------------------------------------
    // Driver: change request signals at the falling edge. Hold an offered
    // item until its transfer, then idle for its gap before the next one.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        lcd_request_t rq;
        if (!stim_on)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !req_taken)
        begin
            // hold: the offered item has not been taken yet
        end
        else if (req_gap > 0)
        begin
            req_ch.valid <= 1'b0;
            req_gap = req_gap - 1;
        end
        else if (pending_requests.size() > 0)
        begin
            rq = pending_requests.pop_front();
            req_ch.opcode      <= rq.opcode;
            req_ch.number      <= rq.number;
            req_ch.digit_value <= rq.digit_value;
            req_ch.position    <= rq.position;
            req_ch.valid       <= 1'b1;
            req_gap = pick_gap(req_quiet);
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall after a transfer for a random gap; drop ready for the
    // whole hold-off stretch.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!stim_on || hold_rsp)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_gap > 0)
        begin
            rsp_ch.ready <= 1'b0;
            rsp_gap = rsp_gap - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (rsp_taken)
                rsp_gap = pick_gap(rsp_quiet);
        end
    end

    // Long hold-off: let the block fill up and stall its request side while
    // the driver keeps offering.
    initial
    begin
        hold_rsp = 1'b0;
        wait (stim_on);
        repeat (HOLD_START) @(posedge clk);
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check a write against the oldest
    // expectation first; a request taken at this edge cannot have produced
    // a write yet, so predict it afterwards.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        lcd_request_t rq;
        lcd_write_t   want;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected write reg %0d value %02h last %0b",
                                 $realtime, rsp_ch.reg_index, rsp_ch.reg_value,
                                 rsp_ch.last_write);
                end
                else
                begin
                    want = expected_writes.pop_front();
                    writes_checked = writes_checked + 1;
                    if (rsp_ch.reg_index !== want.reg_index
                        || rsp_ch.reg_value !== want.reg_value
                        || rsp_ch.last_write !== want.last_write)
                    begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                        begin
                            $display("%0t: write mismatch, expected reg %0d value %02h last %0b",
                                     $realtime, want.reg_index, want.reg_value,
                                     want.last_write);
                            $display("    got reg %0d value %02h last %0b",
                                     rsp_ch.reg_index, rsp_ch.reg_value,
                                     rsp_ch.last_write);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                rq.opcode      = req_ch.opcode;
                rq.number      = req_ch.number;
                rq.digit_value = req_ch.digit_value;
                rq.position    = req_ch.position;
                predict_writes(rq);
                requests_taken = requests_taken + 1;
            end
        end
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
        rsp_taken <= rst_n && rsp_ch.valid && rsp_ch.ready;
    end

    // ------------------------------------------------------------------------
    // Main sequence: fill the request queue, reset, then drain.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned r;
        int          k;
        int          num;
        int          dv;
        int          ps;
        logic [OPCODE_W-1:0] op;

        stim_on        = 1'b0;
        req_taken      = 1'b0;
        rsp_taken      = 1'b0;
        req_gap        = 0;
        req_quiet      = 0;
        rsp_gap        = 0;
        rsp_quiet      = 0;
        mismatch_count = 0;
        requests_taken = 0;
        writes_checked = 0;
        for (k = 0; k < IMAGE_DEPTH; k++)
            shown_image[k] = 8'h00;

        // Directed part: zero, negatives, the extremes of the number, a
        // number too long to show, digits and positions out of range, and
        // fields that the opcode does not read.
        queue_request(OP_NUMBER, 0, 3, 2);
        queue_request(OP_NUMBER, -1, 0, 0);
        queue_request(OP_NUMBER, int'(32'h8000_0000), 9, 5);
        queue_request(OP_NUMBER, 1, -128, 127);
        queue_request(OP_NUMBER, 9, 0, 0);
        queue_request(OP_NUMBER, 10, 0, 0);
        queue_request(OP_NUMBER, 123456, 0, 0);
        queue_request(OP_NUMBER, 999999, 0, 0);
        queue_request(OP_NUMBER, 1000000, 0, 0);
        queue_request(OP_NUMBER, 2147483647, -1, -1);
        for (k = 0; k < 10; k++)
            queue_request(OP_DIGIT, int'($urandom), k, k % DIGITS);
        queue_request(OP_DIGIT, 0, -1, 2);
        queue_request(OP_DIGIT, 0, 10, 3);
        queue_request(OP_DIGIT, 0, 127, 0);
        queue_request(OP_DIGIT, 0, -128, 1);
        queue_request(OP_DIGIT, 0, 4, -1);
        queue_request(OP_DIGIT, 0, 4, 6);
        queue_request(OP_DIGIT, 0, 4, 127);
        queue_request(OP_DIGIT, 0, 4, -128);

        // Random part: mostly numbers and digits that write, some noise.
        while (pending_requests.size() < ITEM_COUNT)
        begin
            r  = $urandom_range(0, 99);
            dv = int'($urandom_range(0, 255));
            ps = int'($urandom_range(0, 255));
            num = int'($urandom);
            if (r < 40)
            begin
                op = OP_NUMBER;
                r  = $urandom_range(0, 99);
                if (r < 15)
                    num = int'($urandom);
                else if (r < 20)
                    num = -int'($urandom_range(1, 1000));
                else if (r < 30)
                    num = int'($urandom & 32'h7FFF_FFFF);
                else
                    num = number_of_digits($urandom_range(1, 7));
            end
            else if (r < 85)
            begin
                op = OP_DIGIT;
                dv = int'($urandom_range(0, 9));
                ps = int'($urandom_range(0, DIGITS - 1));
            end
            else
            begin
                op = OP_DIGIT;
                if (r < 90)
                    dv = int'($urandom_range(0, 9));
                else if (r < 95)
                    ps = int'($urandom_range(0, DIGITS - 1));
            end
            queue_request(op, num, dv, ps);
        end

        // Reset once.
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        stim_on = 1'b1;

        // Wait for every request to be taken, then for every write.
        while (pending_requests.size() != 0 || req_ch.valid)
            @(posedge clk);
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d request transfers and %0d checked register writes,",
                 requests_taken, writes_checked);
        $display("with random idling on both sides and one long receiver hold-off.");
        if (mismatch_count == 0 && expected_writes.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("%0d mismatches, %0d writes never seen",
                     mismatch_count, expected_writes.size());
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("Timed out with %0d writes outstanding", expected_writes.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
